// ===== rtl/core/clcd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and character map for the lcd text writer
package clcd_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'b1;

   localparam logic [5:0] NUM_COLS_RST = 6'd16;
   localparam logic [2:0] NUM_ROWS_RST = 3'd2;

   localparam logic [7:0] LEAD_D0       = 8'hD0;
   localparam logic [7:0] LEAD_D1       = 8'hD1;
   localparam logic [7:0] CHAR_NL       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
   localparam logic [7:0] CMD_SCROLL    = 8'h18;
   localparam logic [7:0] YO_UPPER_CODE = 8'hA2;
   localparam logic [7:0] YO_LOWER_CODE = 8'hB5;

   localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

   // lead 0xd0, second byte 0x90..0xbf
   localparam logic [7:0] MAP_D0 [48] = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE
   };

   // lead 0xd1, second byte 0x80..0x8f
   localparam logic [7:0] MAP_D1 [16] = '{
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   typedef struct packed {
      logic load;
      logic walk_clr;
      logic cnt_exec;
      logic start_addr;
      logic em_exec;
      logic em_data;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic at_end;
      logic scroll;
   } status_type;

   function automatic logic [7:0] map_pair(input logic [7:0] lead, input logic [7:0] second);
      logic [7:0] v;
      logic [7:0] off;
      v   = 8'h00;
      off = second - 8'h90;
      if (lead == LEAD_D0) begin
         if (second inside {[8'h90:8'hBF]}) begin
            v = MAP_D0[off[5:0]];
         end else if (second == 8'h81) begin
            v = YO_UPPER_CODE;
         end
      end else begin
         if (second inside {[8'h80:8'h8F]}) begin
            v = MAP_D1[second[3:0]];
         end else if (second == 8'h91) begin
            v = YO_LOWER_CODE;
         end
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/clcd_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine for load, count and emit passes
module clcd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_last_byte,
   input  clcd_pkg::status_type  status,
   output logic                  busy,
   output clcd_pkg::cmd_type     cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_CNT_RD  = 8'b0000_0010,
      ST_CNT_EX  = 8'b0000_0100,
      ST_ADDR    = 8'b0000_1000,
      ST_EM_RD   = 8'b0001_0000,
      ST_EM_EX   = 8'b0010_0000,
      ST_EM_DATA = 8'b0100_0000,
      ST_FIN     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last_byte) begin
                  cmd.walk_clr = 1'b1;
                  state_in     = ST_CNT_RD;
               end
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_EX;
         end
         ST_CNT_EX: begin
            cmd.cnt_exec = 1'b1;
            state_in     = status.at_end ? ST_ADDR : ST_CNT_RD;
         end
         ST_ADDR: begin
            cmd.start_addr = 1'b1;
            cmd.walk_clr   = 1'b1;
            state_in       = ST_EM_RD;
         end
         ST_EM_RD: begin
            state_in = ST_EM_EX;
         end
         ST_EM_EX: begin
            cmd.em_exec = 1'b1;
            if (status.scroll) begin
               state_in = ST_EM_DATA;
            end else if (status.at_end) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_EM_RD;
            end
         end
         ST_EM_DATA: begin
            cmd.em_data = 1'b1;
            state_in    = status.at_end ? ST_FIN : ST_EM_RD;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/clcd_datapath.sv =====
`timescale 1ns / 1ps
// string buffer, cursor, character count and write output registers
module clcd_datapath #(
   parameter int LINE_WIDTH = 16,
   parameter int MAX_BYTES  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  clcd_pkg::cmd_type              cmd,
   output clcd_pkg::status_type           status,
   input  logic [7:0]                     req_text_byte,
   input  logic [7:0]                     req_target_row,
   input  logic                           csr_wr_en,
   input  logic [clcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [clcd_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output logic                           rsp_valid,
   output logic                           rsp_is_data,
   output logic [7:0]                     rsp_bus_byte,
   output logic                           rsp_last_write
);

   localparam int AW = $clog2(MAX_BYTES);
   localparam int CW = $clog2(MAX_BYTES + 1);
   localparam logic [7:0] HALF_WIDTH = 8'(LINE_WIDTH / 2);
   localparam logic [CW-1:0] FILL_MAX = CW'(MAX_BYTES);

   logic [7:0]    mem_ff [MAX_BYTES];
   logic [7:0]    rd_data_ff;

   logic [5:0]    num_cols_ff;
   logic [2:0]    num_rows_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [7:0]    first_row_ff, first_row_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pair_ff, pair_in;
   logic [7:0]    lead_ff, lead_in;
   logic [7:0]    char_ff, char_in;
   logic [7:0]    col_ff, col_in;
   logic [1:0]    row_ff, row_in;
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_data_ff, pend_data_in;
   logic [7:0]    pend_byte_ff, pend_byte_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_data_ff, out_data_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;

   logic          at_end;
   logic          is_lead;
   logic          is_nl;
   logic          is_cr;
   logic          is_char;
   logic          need_scroll;
   logic [7:0]    char_val;
   logic [7:0]    start_col;
   logic [7:0]    sa_col;
   logic [7:0]    sa_row;
   logic [1:0]    sa_row_ok;
   logic [7:0]    sa_byte;
   logic          push;
   logic          push_data;
   logic [7:0]    push_byte;

   assign at_end      = (CW'(idx_ff) + CW'(1)) >= fill_ff;
   assign is_lead     = (rd_data_ff == clcd_pkg::LEAD_D0) || (rd_data_ff == clcd_pkg::LEAD_D1);
   assign is_nl       = (rd_data_ff == clcd_pkg::CHAR_NL);
   assign is_cr       = (rd_data_ff == clcd_pkg::CHAR_CR);
   assign is_char     = pair_ff || !(is_nl || is_cr || is_lead);
   assign need_scroll = col_ff >= {2'b00, num_cols_ff};
   assign char_val    = pair_ff ? clcd_pkg::map_pair(lead_ff, rd_data_ff) : rd_data_ff;
   assign start_col   = HALF_WIDTH - 8'(count_ff >> 1);

   assign status.at_end = at_end;
   assign status.scroll = is_char && need_scroll;

   // set-address source: start of string, newline or carriage return
   always_comb begin
      sa_col = start_col;
      sa_row = first_row_ff;
      if (cmd.em_exec) begin
         if (is_nl) begin
            sa_col = col_ff;
            sa_row = {6'd0, row_ff} + 8'd1;
         end else begin
            sa_col = 8'd0;
            sa_row = {6'd0, row_ff};
         end
      end
   end

   assign sa_row_ok = (sa_row >= {5'd0, num_rows_ff}) ? 2'd0 : sa_row[1:0];
   assign sa_byte   = clcd_pkg::CMD_SET_ADDR | (sa_col + clcd_pkg::ROW_BASE[sa_row_ok]);

   always_comb begin
      fill_in       = fill_ff;
      first_row_in  = first_row_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pair_in       = pair_ff;
      lead_in       = lead_ff;
      char_in       = char_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      push          = 1'b0;
      push_data     = 1'b0;
      push_byte     = 8'd0;

      if (cmd.load && (fill_ff < FILL_MAX)) begin
         fill_in = fill_ff + CW'(1);
         if (fill_ff == '0) begin
            first_row_in = req_target_row;
         end
      end

      if (cmd.walk_clr) begin
         idx_in   = '0;
         count_in = '0;
         pair_in  = 1'b0;
      end

      if (cmd.cnt_exec) begin
         idx_in = idx_ff + AW'(1);
         if (pair_ff) begin
            pair_in = 1'b0;
         end else if (is_lead) begin
            if (!at_end) begin
               count_in = count_ff + CW'(1);
               pair_in  = 1'b1;
            end
         end else begin
            count_in = count_ff + CW'(1);
         end
      end

      if (cmd.start_addr) begin
         push      = 1'b1;
         push_byte = sa_byte;
         col_in    = sa_col;
         row_in    = sa_row_ok;
      end

      if (cmd.em_exec) begin
         if (!pair_ff && (is_nl || is_cr)) begin
            push      = 1'b1;
            push_byte = sa_byte;
            col_in    = sa_col;
            row_in    = sa_row_ok;
            idx_in    = idx_ff + AW'(1);
         end else if (!pair_ff && is_lead) begin
            if (!at_end) begin
               pair_in = 1'b1;
               lead_in = rd_data_ff;
            end
            idx_in = idx_ff + AW'(1);
         end else begin
            pair_in = 1'b0;
            push    = 1'b1;
            if (need_scroll) begin
               push_byte = clcd_pkg::CMD_SCROLL;
               col_in    = col_ff - 8'd1;
               char_in   = char_val;
            end else begin
               push_data = 1'b1;
               push_byte = char_val;
               col_in    = col_ff + 8'd1;
               idx_in    = idx_ff + AW'(1);
            end
         end
      end

      if (cmd.em_data) begin
         push      = 1'b1;
         push_data = 1'b1;
         push_byte = char_ff;
         col_in    = col_ff + 8'd1;
         idx_in    = idx_ff + AW'(1);
      end

      if (cmd.finish) begin
         fill_in = '0;
      end
   end

   // one write held back so the final one can be flagged
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      pend_byte_in  = pend_byte_ff;
      out_valid_in  = 1'b0;
      out_data_in   = pend_data_ff;
      out_byte_in   = pend_byte_ff;
      out_last_in   = 1'b0;
      if (push) begin
         out_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_data_in  = push_data;
         pend_byte_in  = push_byte;
      end
      if (cmd.finish) begin
         out_valid_in  = pend_valid_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (fill_ff < FILL_MAX)) begin
         mem_ff[fill_ff[AW-1:0]] <= req_text_byte;
      end
      rd_data_ff <= mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff   <= clcd_pkg::NUM_COLS_RST;
         num_rows_ff   <= clcd_pkg::NUM_ROWS_RST;
         fill_ff       <= '0;
         first_row_ff  <= 8'd0;
         idx_ff        <= '0;
         count_ff      <= '0;
         pair_ff       <= 1'b0;
         col_ff        <= 8'd0;
         row_ff        <= 2'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               clcd_pkg::CSR_NUM_COLS: num_cols_ff <= csr_wr_data;
               clcd_pkg::CSR_NUM_ROWS: num_rows_ff <= csr_wr_data[2:0];
               default: ;
            endcase
         end
         fill_ff       <= fill_in;
         first_row_ff  <= first_row_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         pair_ff       <= pair_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff      <= lead_in;
      char_ff      <= char_in;
      pend_data_ff <= pend_data_in;
      pend_byte_ff <= pend_byte_in;
      out_data_ff  <= out_data_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_is_data    = out_data_ff;
   assign rsp_bus_byte   = out_byte_ff;
   assign rsp_last_write = out_last_ff;

endmodule

// ===== rtl/core/cyrillic_lcd_text_writer.sv =====
`timescale 1ns / 1ps
// top level: centered text writer for a character display controller
// a request that is not the last byte of a string is taken at once, busy stays low
// the last byte starts emit: a count pass with a read and a count state per stored byte, a set-address
// state, an emit pass with a read and an emit state per stored byte plus a data state per scroll, and a
// closing state; the buffer's single registered read port is why each byte is read first. the final
// write is strobed on rsp_ in the same cycle that busy falls. synchronous reset clears the string and cursor
module cyrillic_lcd_text_writer #(
   parameter int LINE_WIDTH = 16,
   parameter int MAX_BYTES  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [7:0]                      req_text_byte,
   input  logic [7:0]                      req_target_row,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   output logic                            rsp_is_data,
   output logic [7:0]                      rsp_bus_byte,
   output logic                            rsp_last_write,
   input  logic                            csr_wr_en,
   input  logic [clcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [clcd_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   clcd_pkg::cmd_type    cmd;
   clcd_pkg::status_type status;

   clcd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_byte (req_last_byte),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   clcd_datapath #(
      .LINE_WIDTH (LINE_WIDTH),
      .MAX_BYTES  (MAX_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_text_byte  (req_text_byte),
      .req_target_row (req_target_row),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_is_data    (rsp_is_data),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_last_write (rsp_last_write)
   );

   a_final_write_on_done : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_last_write))
      else $error("emit finished without a final write");

   a_last_write_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_write) |-> !busy)
      else $error("final write while still busy");

   a_plain_byte_no_emit : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_byte) |=> (!busy && !rsp_valid))
      else $error("non-final request started emit");

endmodule

// ===== tb/cyrillic_lcd_text_writer_checker.sv =====
`timescale 1ns / 1ps
// checker for the lcd text writer: predicts controller writes and compares the rsp stream
module cyrillic_lcd_text_writer_checker #(
   parameter int LINE_WIDTH = 16,
   parameter int MAX_BYTES  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [7:0]                      req_text_byte,
   input  logic [7:0]                      req_target_row,
   input  logic                            req_last_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_is_data,
   input  logic [7:0]                      rsp_bus_byte,
   input  logic                            rsp_last_write,
   input  logic                            csr_wr_en,
   input  logic [clcd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [clcd_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                              error_count,
   output int                              writes_outstanding
);

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last_write;
   } lcd_write_type;

   lcd_write_type lcd_writes_q [$];

   logic [7:0] str_buf [MAX_BYTES];
   logic [4:0] fill_cnt;
   logic [7:0] first_row;
   logic [7:0] cur_col;
   logic [1:0] cur_row;
   logic [5:0] cols_cfg;
   logic [2:0] rows_cfg;
   int         errors;

   function automatic logic is_lead(input logic [7:0] b);
      return (b == clcd_pkg::LEAD_D0) || (b == clcd_pkg::LEAD_D1);
   endfunction

   function automatic logic [7:0] cyrillic_code(input logic [7:0] lead, input logic [7:0] second);
      logic [7:0] code;
      logic [7:0] idx;
      code = 8'h00;
      idx  = second - 8'h90;
      if (lead == clcd_pkg::LEAD_D0) begin
         if (second >= 8'h90 && second <= 8'hBF) begin
            code = clcd_pkg::MAP_D0[idx[5:0]];
         end else if (second == 8'h81) begin
            code = clcd_pkg::YO_UPPER_CODE;
         end
      end else if (second >= 8'h80 && second <= 8'h8F) begin
         code = clcd_pkg::MAP_D1[second[3:0]];
      end else if (second == 8'h91) begin
         code = clcd_pkg::YO_LOWER_CODE;
      end
      return code;
   endfunction

   task automatic push_write(input logic is_data, input logic [7:0] value);
      lcd_write_type w;
      w.is_data    = is_data;
      w.bus_byte   = value;
      w.last_write = 1'b0;
      lcd_writes_q.push_back(w);
   endtask

   task automatic move_cursor(input logic [7:0] col, input int row);
      int         r;
      logic [7:0] addr;
      r = row;
      if (r >= int'(rows_cfg)) begin
         r = 0;
      end
      r       = r & 3;
      cur_col = col;
      cur_row = r[1:0];
      addr    = col + clcd_pkg::ROW_BASE[r];
      push_write(1'b0, clcd_pkg::CMD_SET_ADDR | addr);
   endtask

   task automatic compute_string_writes();
      int            n;
      int            i;
      int            chars;
      logic [7:0]    b;
      logic [7:0]    col0;
      lcd_write_type tail;
      n     = int'(fill_cnt);
      i     = 0;
      chars = 0;
      while (i < n) begin
         if (is_lead(str_buf[i])) begin
            if (i + 1 >= n) break;
            i += 2;
         end else begin
            i += 1;
         end
         chars++;
      end
      col0 = 8'(LINE_WIDTH / 2 - chars / 2);
      move_cursor(col0, int'(first_row));
      i = 0;
      while (i < n) begin
         b = str_buf[i];
         if (b == clcd_pkg::CHAR_NL) begin
            move_cursor(cur_col, int'(cur_row) + 1);
            i++;
         end else if (b == clcd_pkg::CHAR_CR) begin
            move_cursor(8'd0, int'(cur_row));
            i++;
         end else begin
            if (is_lead(b) && i + 1 >= n) break;
            if (cur_col >= {2'b00, cols_cfg}) begin
               push_write(1'b0, clcd_pkg::CMD_SCROLL);
               cur_col = cur_col - 8'd1;
            end
            if (is_lead(b)) begin
               push_write(1'b1, cyrillic_code(b, str_buf[i+1]));
               i += 2;
            end else begin
               push_write(1'b1, b);
               i++;
            end
            cur_col = cur_col + 8'd1;
         end
      end
      tail = lcd_writes_q.pop_back();
      tail.last_write = 1'b1;
      lcd_writes_q.push_back(tail);
   endtask

   always @(posedge clock) begin : monitor
      lcd_write_type got;
      lcd_write_type want;
      if (reset) begin
         lcd_writes_q.delete();
         fill_cnt  = '0;
         first_row = '0;
         cur_col   = '0;
         cur_row   = '0;
         cols_cfg  = clcd_pkg::NUM_COLS_RST;
         rows_cfg  = clcd_pkg::NUM_ROWS_RST;
      end else begin
         if (rsp_valid) begin
            got.is_data    = rsp_is_data;
            got.bus_byte   = rsp_bus_byte;
            got.last_write = rsp_last_write;
            if (lcd_writes_q.size() == 0) begin
               if (errors < 10) begin
                  $display("rsp with nothing outstanding: is_data=%0d byte=%02h last=%0d",
                           got.is_data, got.bus_byte, got.last_write);
               end
               errors++;
            end else begin
               want = lcd_writes_q.pop_front();
               if (got.is_data !== want.is_data || got.bus_byte !== want.bus_byte ||
                   got.last_write !== want.last_write) begin
                  if (errors < 10) begin
                     $display("rsp mismatch: exp is_data=%0d byte=%02h last=%0d, %s %0d %02h %0d",
                              want.is_data, want.bus_byte, want.last_write, "got",
                              got.is_data, got.bus_byte, got.last_write);
                  end
                  errors++;
               end
            end
         end
         if (csr_wr_en) begin
            if (csr_index == clcd_pkg::CSR_NUM_COLS) begin
               cols_cfg = csr_wr_data[5:0];
            end else if (csr_index == clcd_pkg::CSR_NUM_ROWS) begin
               rows_cfg = csr_wr_data[2:0];
            end
         end
         if (start && !busy) begin
            if (int'(fill_cnt) < MAX_BYTES) begin
               if (fill_cnt == 0) begin
                  first_row = req_target_row;
               end
               str_buf[fill_cnt] = req_text_byte;
               fill_cnt = fill_cnt + 5'd1;
            end
            if (req_last_byte) begin
               compute_string_writes();
               fill_cnt = '0;
            end
         end
      end
      error_count        <= errors;
      writes_outstanding <= lcd_writes_q.size();
   end

endmodule

// ===== tb/tb_cyrillic_lcd_text_writer.sv =====
`timescale 1ns / 1ps
// testbench top for the lcd text writer: clock, reset, request stimulus and verdict
module tb_cyrillic_lcd_text_writer;

   localparam int LINE_WIDTH = 16;
   localparam int MAX_BYTES  = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASE_ITEMS = 24;

   typedef logic [7:0] text_q_type [$];

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [7:0]                      req_text_byte = '0;
   logic [7:0]                      req_target_row = '0;
   logic                            req_last_byte = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_is_data;
   logic [7:0]                      rsp_bus_byte;
   logic                            rsp_last_write;
   logic                            csr_wr_en = 1'b0;
   logic [clcd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [clcd_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;
   int                              error_count;
   int                              writes_outstanding;
   int                              cycle_cnt = 0;
   int                              items_sent = 0;
   logic                            no_idle = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   cyrillic_lcd_text_writer #(
      .LINE_WIDTH (LINE_WIDTH),
      .MAX_BYTES  (MAX_BYTES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_text_byte  (req_text_byte),
      .req_target_row (req_target_row),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_is_data    (rsp_is_data),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_last_write (rsp_last_write),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   cyrillic_lcd_text_writer_checker #(
      .LINE_WIDTH (LINE_WIDTH),
      .MAX_BYTES  (MAX_BYTES)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_text_byte      (req_text_byte),
      .req_target_row     (req_target_row),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_is_data        (rsp_is_data),
      .rsp_bus_byte       (rsp_bus_byte),
      .rsp_last_write     (rsp_last_write),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .error_count        (error_count),
      .writes_outstanding (writes_outstanding)
   );

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // optional gap, then one request held until taken
   task automatic send_request(input logic [7:0] text_byte, input logic [7:0] row,
                               input logic last);
      int gap;
      gap = no_idle ? 0 : gap_len();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_text_byte  <= text_byte;
      req_target_row <= row;
      req_last_byte  <= last;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input text_q_type text, input logic [7:0] row);
      for (int k = 0; k < text.size(); k++) begin
         send_request(text[k], row, k == text.size() - 1);
      end
   endtask

   task automatic send_random_text();
      text_q_type text;
      int         len;
      int         r;
      logic [7:0] lead;
      logic [7:0] second;
      logic [7:0] row;
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 16);
      else len = $urandom_range(17, 22);
      row = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(0, 255));
      while (text.size() < len) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            text.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end else if (r < 48) begin
            text.push_back(clcd_pkg::CHAR_NL);
         end else if (r < 54) begin
            text.push_back(clcd_pkg::CHAR_CR);
         end else if (r < 82) begin
            lead = $urandom_range(0, 1) ? clcd_pkg::LEAD_D1 : clcd_pkg::LEAD_D0;
            r = $urandom_range(0, 9);
            if (r < 7) begin
               second = (lead == clcd_pkg::LEAD_D0) ? 8'($urandom_range(8'h90, 8'hBF))
                                                    : 8'($urandom_range(8'h80, 8'h8F));
            end else if (r < 8) begin
               second = (lead == clcd_pkg::LEAD_D0) ? 8'h81 : 8'h91;
            end else begin
               second = 8'($urandom_range(0, 255));
            end
            text.push_back(lead);
            text.push_back(second);
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      // trailing lone lead byte
      if ($urandom_range(0, 9) == 0) begin
         text.push_back($urandom_range(0, 1) ? clcd_pkg::LEAD_D1 : clcd_pkg::LEAD_D0);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      send_text(text, row);
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (writes_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_geometry(input logic [5:0] cols, input logic [2:0] rows);
      csr_wr_en   <= 1'b1;
      csr_index   <= clcd_pkg::CSR_NUM_COLS;
      csr_wr_data <= cols;
      @(posedge clock);
      csr_index   <= clcd_pkg::CSR_NUM_ROWS;
      csr_wr_data <= {3'b000, rows};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      text_q_type text;
      logic [5:0] cols_list [6];
      logic [2:0] rows_list [6];
      int         phase_start;
      cols_list = '{6'd1, 6'd40, 6'd0, 6'd63, 6'($urandom_range(1, 40)), 6'd5};
      rows_list = '{3'd1, 3'd4, 3'd0, 3'd7, 3'($urandom_range(1, 4)), 3'd3};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed strings at reset geometry
      text = {8'hFF};
      send_text(text, 8'hFF);
      text = {clcd_pkg::LEAD_D0, 8'h81, clcd_pkg::CHAR_NL, clcd_pkg::LEAD_D1, 8'h91,
              clcd_pkg::CHAR_CR, 8'h00, clcd_pkg::LEAD_D0, 8'h90, clcd_pkg::LEAD_D1,
              8'h8F, clcd_pkg::LEAD_D1};
      send_text(text, 8'h01);
      text = {clcd_pkg::LEAD_D0, 8'h00};
      send_text(text, 8'h00);
      text = {clcd_pkg::LEAD_D1};
      send_text(text, 8'h00);
      text = {clcd_pkg::CHAR_NL, clcd_pkg::CHAR_NL, clcd_pkg::CHAR_NL};
      send_text(text, 8'h03);

      for (int p = 0; p < 6; p++) begin
         wait_quiet();
         write_geometry(cols_list[p], rows_list[p]);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_random_text();
         end
      end

      wait_quiet();
      if (error_count == 0 && writes_outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
